### design/fnpll_pkg.sv
`timescale 1ns / 1ps

package fnpll_pkg;

    localparam int REQ_W      = 16;
    localparam int FREF_W     = 16;
    localparam int RDIV_W     = 14;
    localparam int RUSED_W    = 15;
    localparam int BAND_W     = 24;
    localparam int INT_W      = 19;
    localparam int FRAC_OUT_W = 24;
    localparam int MODE_W     = 10;
    localparam int VCO_W      = 16;
    localparam int PROD_W     = VCO_W + RDIV_W;
    localparam int NUM_W      = PROD_W + 1;
    localparam int DIV_W      = FREF_W + 1;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [1:0] REG_REF_FREQ = 2'd0;
    localparam logic [1:0] REG_REF_DIV  = 2'd1;
    localparam logic [1:0] REG_FB_BAND  = 2'd2;

    localparam logic [FREF_W-1:0] REF_FREQ_RST = 16'd800;
    localparam logic [RDIV_W-1:0] REF_DIV_RST  = 14'd1;
    localparam logic [BAND_W-1:0] FB_BAND_RST  = 24'h00E090;

    localparam logic [BAND_W-1:0] BAND_X1  = 24'h00E090;
    localparam logic [BAND_W-1:0] BAND_X2  = 24'h006110;
    localparam logic [BAND_W-1:0] BAND_X4  = 24'h00E210;
    localparam logic [BAND_W-1:0] BAND_X8  = 24'h00E410;
    localparam logic [BAND_W-1:0] BAND_X16 = 24'h00E810;
    localparam logic [BAND_W-1:0] BAND_X32 = 24'h00F010;
    localparam logic [BAND_W-1:0] BAND_X62 = 24'h00FF10;

    localparam logic [VCO_W-1:0] FALLBACK_VCO = 16'd36800;

    localparam logic [MODE_W-1:0] MODE_INT  = 10'h100;
    localparam logic [MODE_W-1:0] MODE_FRAC = 10'h17F;

    typedef struct packed {
        logic [BAND_W-1:0]  band;
        logic [RUSED_W-1:0] r_used;
        logic               oob;
    } t_tag;

endpackage

### design/fnpll_req_if.sv
`timescale 1ns / 1ps

interface fnpll_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] freq_request;

    modport source (output valid, output freq_request, input ready);
    modport sink (input valid, input freq_request, output ready);
endinterface

### design/fnpll_res_if.sv
`timescale 1ns / 1ps

interface fnpll_res_if;
    logic        valid;
    logic        ready;
    logic [23:0] band_word;
    logic [18:0] int_divider;
    logic [23:0] frac_divider;
    logic [14:0] ref_divider_used;
    logic [9:0]  mode_word;
    logic        out_of_band;
    logic        int_overflow;

    modport source (output valid, output band_word, output int_divider, output frac_divider,
                    output ref_divider_used, output mode_word, output out_of_band,
                    output int_overflow, input ready);
    modport sink (input valid, input band_word, input int_divider, input frac_divider,
                  input ref_divider_used, input mode_word, input out_of_band,
                  input int_overflow, output ready);
endinterface

### design/frac_n_pll_divider_calc_unit.sv
`timescale 1ns / 1ps
// channel   dir  handshake      payload
// i_req     in   valid/ready    freq_request
// o_res     out  valid/ready    band_word, int_divider, frac_divider, ref_divider_used,
//                               mode_word, out_of_band, int_overflow
// apb       in   psel/penable   paddr, pwdata, prdata (pready tied high)
//
// one request per cycle sustained while o_res is not stalled; stages a, b, c, the divider and
// the output stage are registered in turn; the divider is restoring, one quotient bit per stage
// i_rst_n is synchronous, active low, and clears all valid bits and the configuration registers
// a stall on o_res backs up stage by stage, bubbles are filled before i_req stops

module frac_n_pll_divider_calc_unit #(
    parameter int FRAC_BITS   = 24,
    parameter int MIN_INT_DIV = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fnpll_req_if.sink   i_req,
    fnpll_res_if.source o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NUM_W = fnpll_pkg::NUM_W;
    localparam int DW    = fnpll_pkg::DIV_W;
    localparam int XW    = NUM_W + FRAC_BITS + 1;
    localparam int THR_W = fnpll_pkg::FREF_W + 7;

    logic [15:0] r_ref_freq;
    logic [13:0] r_ref_div;
    logic [23:0] r_fb_band;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_freq <= fnpll_pkg::REF_FREQ_RST;
            r_ref_div  <= fnpll_pkg::REF_DIV_RST;
            r_fb_band  <= fnpll_pkg::FB_BAND_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                fnpll_pkg::REG_REF_FREQ: r_ref_freq <= pwdata[15:0];
                fnpll_pkg::REG_REF_DIV:  r_ref_div  <= pwdata[13:0];
                fnpll_pkg::REG_FB_BAND:  r_fb_band  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            fnpll_pkg::REG_REF_FREQ: prdata = {16'b0, r_ref_freq};
            fnpll_pkg::REG_REF_DIV:  prdata = {18'b0, r_ref_div};
            fnpll_pkg::REG_FB_BAND:  prdata = {8'b0, r_fb_band};
            default:                 prdata = '0;
        endcase
    end

    logic [15:0]      w_fref;
    logic [THR_W-1:0] w_thr;
    assign w_fref = (r_ref_freq == '0) ? 16'd1 : r_ref_freq;
    assign w_thr  = THR_W'(MIN_INT_DIV) * THR_W'(w_fref);

    logic w_rdy_a, w_rdy_b, w_rdy_c, w_div_rdy, w_out_rdy;

    // stage a: band select and vco scaling
    logic        r_a_v;
    logic [15:0] r_a_vco;
    logic [23:0] r_a_band;
    logic        r_a_oob;
    logic [15:0] n_a_vco;
    logic [23:0] n_a_band;
    logic        n_a_oob;
    logic [15:0] w_f;
    logic [21:0] w_f62;

    assign w_f   = i_req.freq_request;
    assign w_f62 = {w_f, 6'b0} - {5'b0, w_f, 1'b0};

    always_comb begin
        n_a_oob = 1'b0;
        if (w_f >= 16'd24000 && w_f <= 16'd48000) begin
            n_a_vco  = w_f;
            n_a_band = fnpll_pkg::BAND_X1;
        end else if (w_f >= 16'd12000 && w_f < 16'd24000) begin
            n_a_vco  = {w_f[14:0], 1'b0};
            n_a_band = fnpll_pkg::BAND_X2;
        end else if (w_f >= 16'd6000 && w_f < 16'd12000) begin
            n_a_vco  = {w_f[13:0], 2'b0};
            n_a_band = fnpll_pkg::BAND_X4;
        end else if (w_f >= 16'd3000 && w_f < 16'd6000) begin
            n_a_vco  = {w_f[12:0], 3'b0};
            n_a_band = fnpll_pkg::BAND_X8;
        end else if (w_f >= 16'd1500 && w_f < 16'd3000) begin
            n_a_vco  = {w_f[11:0], 4'b0};
            n_a_band = fnpll_pkg::BAND_X16;
        end else if (w_f >= 16'd750 && w_f < 16'd1500) begin
            n_a_vco  = {w_f[10:0], 5'b0};
            n_a_band = fnpll_pkg::BAND_X32;
        end else if (w_f >= 16'd375 && w_f < 16'd750) begin
            n_a_vco  = w_f62[15:0];
            n_a_band = fnpll_pkg::BAND_X62;
        end else begin
            n_a_vco  = fnpll_pkg::FALLBACK_VCO;
            n_a_band = r_fb_band;
            n_a_oob  = 1'b1;
        end
    end

    assign w_rdy_a     = !r_a_v || w_rdy_b;
    assign i_req.ready = w_rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_rdy_a) begin
            r_a_v <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_req.valid) begin
            r_a_vco  <= n_a_vco;
            r_a_band <= n_a_band;
            r_a_oob  <= n_a_oob;
        end
    end

    // stage b: vco times r
    logic             r_b_v;
    logic [NUM_W-2:0] r_b_prod;
    logic [23:0]      r_b_band;
    logic             r_b_oob;

    assign w_rdy_b = !r_b_v || w_rdy_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_rdy_b) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_b && r_a_v) begin
            r_b_prod <= (NUM_W - 1)'(r_a_vco) * (NUM_W - 1)'(r_ref_div);
            r_b_band <= r_a_band;
            r_b_oob  <= r_a_oob;
        end
    end

    // stage c: r doubling below the minimum integer ratio
    logic           r_c_v;
    logic [NUM_W-1:0] r_c_num;
    logic [14:0]    r_c_r;
    logic [23:0]    r_c_band;
    logic           r_c_oob;
    logic           w_dbl;

    assign w_dbl   = r_b_prod < (NUM_W - 1)'(w_thr);
    assign w_rdy_c = !r_c_v || w_div_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_rdy_c) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_c && r_b_v) begin
            r_c_num  <= w_dbl ? {r_b_prod, 1'b0} : {1'b0, r_b_prod};
            r_c_r    <= w_dbl ? {r_ref_div, 1'b0} : {1'b0, r_ref_div};
            r_c_band <= r_b_band;
            r_c_oob  <= r_b_oob;
        end
    end

    // q = (num * 2^(F+1) + fref) / (2 * fref), rounding carry lands in the integer part
    logic [XW-1:0]   w_x;
    logic [DW-1:0]   w_d;
    fnpll_pkg::t_tag w_tag_in;
    logic            w_div_v;
    logic [XW-1:0]   w_q;
    fnpll_pkg::t_tag w_tag_out;

    assign w_x      = {r_c_num, (FRAC_BITS + 1)'(w_fref)};
    assign w_d      = {w_fref, 1'b0};
    assign w_tag_in = '{band: r_c_band, r_used: r_c_r, oob: r_c_oob};

    fnpll_div #(
        .XW (XW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c_v),
        .o_ready (w_div_rdy),
        .i_x     (w_x),
        .i_d     (w_d),
        .i_tag   (w_tag_in),
        .o_valid (w_div_v),
        .i_ready (w_out_rdy),
        .o_q     (w_q),
        .o_tag   (w_tag_out)
    );

    // output stage: saturation and mode
    logic                    w_ovf;
    logic [FRAC_BITS-1:0]    w_frac;
    logic [FRAC_BITS+23:0]   w_frac_ext;
    logic [18:0]             w_int;
    logic [9:0]              w_mode;

    assign w_ovf      = |w_q[XW-1:FRAC_BITS+19];
    assign w_frac     = w_ovf ? '1 : w_q[FRAC_BITS-1:0];
    assign w_frac_ext = {24'b0, w_frac};
    assign w_int      = w_ovf ? '1 : w_q[FRAC_BITS+18:FRAC_BITS];
    assign w_mode     = (w_frac == '0) ? fnpll_pkg::MODE_INT : fnpll_pkg::MODE_FRAC;

    logic        r_o_v;
    logic [23:0] r_o_band;
    logic [18:0] r_o_int;
    logic [23:0] r_o_frac;
    logic [14:0] r_o_r;
    logic [9:0]  r_o_mode;
    logic        r_o_oob;
    logic        r_o_ovf;

    assign w_out_rdy = !r_o_v || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_out_rdy) begin
            r_o_v <= w_div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy && w_div_v) begin
            r_o_band <= w_tag_out.band;
            r_o_int  <= w_int;
            r_o_frac <= w_frac_ext[23:0];
            r_o_r    <= w_tag_out.r_used;
            r_o_mode <= w_mode;
            r_o_oob  <= w_tag_out.oob;
            r_o_ovf  <= w_ovf;
        end
    end

    assign o_res.valid            = r_o_v;
    assign o_res.band_word        = r_o_band;
    assign o_res.int_divider      = r_o_int;
    assign o_res.frac_divider     = r_o_frac;
    assign o_res.ref_divider_used = r_o_r;
    assign o_res.mode_word        = r_o_mode;
    assign o_res.out_of_band      = r_o_oob;
    assign o_res.int_overflow     = r_o_ovf;

`ifndef SYNTHESIS
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v && r_o_ovf |-> r_o_int == '1 && r_o_mode == fnpll_pkg::MODE_FRAC)
        else $error("overflow result not saturated");

    a_frac_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v && r_o_frac != '0 |-> r_o_mode == fnpll_pkg::MODE_FRAC)
        else $error("nonzero fraction in integer mode");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_v && !w_rdy_b |=> r_a_v && $stable(r_a_vco) && $stable(r_a_band))
        else $error("stalled stage a lost its item");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_o_v && !r_a_v)
        else $error("pipeline not empty after reset");
`endif

endmodule

### design/fnpll_div.sv
`timescale 1ns / 1ps

module fnpll_div #(
    parameter int XW = 56,
    parameter int DW = 17
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [XW-1:0]      i_x,
    input  logic [DW-1:0]      i_d,
    input  fnpll_pkg::t_tag    i_tag,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [XW-1:0]      o_q,
    output fnpll_pkg::t_tag    o_tag
);

    logic [XW-1:0]   r_v;
    logic [DW-1:0]   r_rem [XW];
    logic [XW-1:0]   r_z   [XW];
    fnpll_pkg::t_tag r_tag [XW];
    logic [XW:0]     w_rdy;

    assign w_rdy[XW] = i_ready;

    genvar k;
    generate
        for (k = 0; k < XW; k++) begin : g_stage
            logic            w_pv;
            logic [DW-1:0]   w_prem;
            logic [XW-1:0]   w_pz;
            fnpll_pkg::t_tag w_ptag;
            logic [DW:0]     w_t;
            logic            w_ge;
            logic [DW:0]     w_sub;
            logic [DW-1:0]   n_rem;
            logic [XW-1:0]   n_z;

            if (k == 0) begin : g_first
                assign w_pv   = i_valid;
                assign w_prem = '0;
                assign w_pz   = i_x;
                assign w_ptag = i_tag;
            end else begin : g_next
                assign w_pv   = r_v[k-1];
                assign w_prem = r_rem[k-1];
                assign w_pz   = r_z[k-1];
                assign w_ptag = r_tag[k-1];
            end

            assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

            always_comb begin
                w_t   = {w_prem, w_pz[XW-1]};
                w_ge  = (w_t >= {1'b0, i_d});
                w_sub = w_t - {1'b0, i_d};
                n_rem = w_ge ? w_sub[DW-1:0] : w_t[DW-1:0];
                n_z   = {w_pz[XW-2:0], w_ge};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (w_rdy[k]) begin
                    r_v[k] <= w_pv;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[k] && w_pv) begin
                    r_rem[k] <= n_rem;
                    r_z[k]   <= n_z;
                    r_tag[k] <= w_ptag;
                end
            end
        end
    endgenerate

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[XW-1];
    assign o_q     = r_z[XW-1];
    assign o_tag   = r_tag[XW-1];

endmodule
